[hw/rtl/nbcs_pkg.sv]
// Shared types, codes and helpers for the NAND bus cycle sequencer.
package nbcs_pkg;

  localparam int RunDepth = 5;
  localparam int CntW = 3;

  // Action codes carried on s_tuser.
  localparam logic [2:0] ACT_STATIC = 3'd0;
  localparam logic [2:0] ACT_CMD    = 3'd1;
  localparam logic [2:0] ACT_ADDR   = 3'd2;
  localparam logic [2:0] ACT_READ   = 3'd3;
  localparam logic [2:0] ACT_POLL   = 3'd4;

  // Error codes carried on m_tuser.
  localparam logic [2:0] ERR_OK  = 3'd0;
  localparam logic [2:0] ERR_CE  = 3'd1;
  localparam logic [2:0] ERR_CLE = 3'd2;
  localparam logic [2:0] ERR_RE  = 3'd3;
  localparam logic [2:0] ERR_WE  = 3'd4;
  localparam logic [2:0] ERR_ALE = 3'd5;

  // Bit positions in the control pin vector.
  localparam int PIN_CLE = 0;
  localparam int PIN_ALE = 1;
  localparam int PIN_NCE = 2;
  localparam int PIN_NWE = 3;
  localparam int PIN_NRE = 4;
  localparam int PIN_NWP = 5;

  typedef struct packed {
    logic       wp_n_level;
    logic       re_n_level;
    logic       ce_n_level;
    logic       ready_in;
    logic [7:0] io_in;
    logic       first;
    logic [7:0] value;
  } item_data_t;

  typedef struct packed {
    logic       last;
    logic [2:0] action;
    item_data_t data;
  } item_t;

  typedef struct packed {
    logic       ready_res;
    logic [7:0] read_data;
    logic       io_drive;
    logic [7:0] io_out;
    logic [5:0] pins;
  } snap_t;

  typedef struct packed {
    logic [2:0] err;
    snap_t      snap;
  } res_t;

  typedef struct packed {
    logic [5:0] pins;
    logic [7:0] io_value;
    logic       io_drive;
  } pin_state_t;

  function automatic res_t mk_res(input logic [5:0] pins, input logic [7:0] io,
                                  input logic drv, input logic [7:0] rd,
                                  input logic rdy, input logic [2:0] err);
    res_t r;
    r.err            = err;
    r.snap.pins      = pins;
    r.snap.io_out    = io;
    r.snap.io_drive  = drv;
    r.snap.read_data = rd;
    r.snap.ready_res = rdy;
    return r;
  endfunction

endpackage

[hw/rtl/nand_bus_cycle_sequencer_core.sv]
// Top level of the x8 NAND bus cycle sequencer.
//
// One input item on the s_ group runs one bus operation: set the static
// nCE/nRE/nWP levels, a command latch cycle, one address byte, one read
// byte, or a ready poll. The block answers with a run of one to five pin
// snapshots on the m_ group, in order; m_tlast marks the final snapshot of
// the run and m_tuser carries the error code (nonzero only on a single
// snapshot whose check failed, with the pins unchanged).
// An accepted item sits in an input register; its whole run is built in
// one pass and loaded into a five-entry snapshot shift register once the
// previous run is drained or its last snapshot is being taken. The shift
// register drains one snapshot per cycle while the receiver takes them. A
// new run loads in the same cycle that the last snapshot of the previous
// run is taken, so the output runs without gaps when the next item waits.
// Unused action codes give no snapshot.
// When the receiver stalls, the run holds and the input register takes one
// more item before s_tready drops. Reset empties both registers and sets
// all pins low with the IO bus driven as output holding zero.
module nand_bus_cycle_sequencer_core
  import nbcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // value[7:0], first[8], io_in[16:9], ready_in[17], ce_n_level[18],
  // re_n_level[19], wp_n_level[20], zero[23:21]
  input  logic [23:0] s_tdata,
  // action[2:0]
  input  logic [2:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cle[0], ale[1], ce_n[2], we_n[3], re_n[4], wp_n[5], io_out[13:6],
  // io_drive[14], read_data[22:15], ready_res[23]
  output logic [23:0] m_tdata,
  // error[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  item_t                       ib;
  logic                        ib_v;
  res_t       [RunDepth-1:0]   run;
  logic       [CntW-1:0]       cnt;
  pin_state_t                  st;

  res_t       [RunDepth-1:0]   gen_run;
  logic       [CntW-1:0]       gen_cnt;
  pin_state_t                  gen_st;

  logic take;
  logic load;

  nbcs_run_gen u_run_gen (
    .item    (ib),
    .st      (st),
    .run     (gen_run),
    .cnt     (gen_cnt),
    .st_next (gen_st)
  );

  assign take     = m_tvalid && m_tready;
  assign load     = ib_v && ((cnt == '0) || ((cnt == CntW'(1)) && take));
  assign s_tready = !ib_v || load;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ib.action <= s_tuser;
      ib.last   <= s_tlast;
      ib.data   <= s_tdata[$bits(item_data_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      ib_v <= 1'b1;
    end else if (load) begin
      ib_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      st.pins     <= '0;
      st.io_value <= '0;
      st.io_drive <= 1'b1;
    end else if (load) begin
      cnt <= gen_cnt;
      st  <= gen_st;
    end else if (take) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Snapshot payload shifts toward entry zero as each one is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      run <= gen_run;
    end else if (take) begin
      for (int i = 0; i < RunDepth - 1; i++) begin
        run[i] <= run[i+1];
      end
    end
  end

  assign m_tvalid = (cnt != '0);
  assign m_tdata  = run[0].snap;
  assign m_tuser  = run[0].err;
  assign m_tlast  = (cnt == CntW'(1));

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(RunDepth))
    else $error("snapshot count beyond run depth");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ERR_OK)) |-> m_tlast)
    else $error("error snapshot is not alone in its run");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(st))
    else $error("pin state changed without a run load");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    load |-> (!m_tvalid || (m_tlast && m_tready)))
    else $error("run loaded over snapshots still pending");

endmodule

[hw/rtl/nbcs_run_gen.sv]
// Builds the full run of pin snapshots for one item and the pin state it leaves.
module nbcs_run_gen
  import nbcs_pkg::*;
(
  input  item_t                         item,
  input  pin_state_t                    st,
  output res_t       [RunDepth-1:0]     run,
  output logic       [CntW-1:0]         cnt,
  output pin_state_t                    st_next
);

  logic [5:0]      p;
  logic [7:0]      io;
  logic            drv;
  logic [CntW-1:0] n;
  logic [2:0]      err;

  always_comb begin
    p   = st.pins;
    io  = st.io_value;
    drv = st.io_drive;
    n   = '0;
    err = ERR_OK;
    run = '0;
    case (item.action)
      ACT_STATIC: begin
        p[PIN_NCE] = item.data.ce_n_level;
        p[PIN_NRE] = item.data.re_n_level;
        p[PIN_NWP] = item.data.wp_n_level;
        run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
      end
      ACT_CMD: begin
        if (p[PIN_NCE]) err = ERR_CE;
        else if (!p[PIN_NRE]) err = ERR_RE;
        if (err != ERR_OK) begin
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, err); n = n + 1'b1;
        end else begin
          p[PIN_CLE] = 1'b1;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          p[PIN_NWE] = 1'b0;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          io = item.data.value;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          p[PIN_NWE] = 1'b1;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          p[PIN_CLE] = 1'b0;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
        end
      end
      ACT_ADDR: begin
        if (p[PIN_NCE]) err = ERR_CE;
        else if (p[PIN_CLE]) err = ERR_CLE;
        else if (!p[PIN_NRE]) err = ERR_RE;
        if (err != ERR_OK) begin
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, err); n = n + 1'b1;
        end else begin
          if (item.data.first) begin
            p[PIN_ALE] = 1'b1;
            run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          end
          p[PIN_NWE] = 1'b0;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          io = item.data.value;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          p[PIN_NWE] = 1'b1;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          if (item.last) begin
            p[PIN_ALE] = 1'b0;
            run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (p[PIN_NCE]) err = ERR_CE;
        else if (!p[PIN_NWE]) err = ERR_WE;
        else if (p[PIN_ALE]) err = ERR_ALE;
        if (err != ERR_OK) begin
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, err); n = n + 1'b1;
        end else begin
          if (item.data.first) begin
            drv = 1'b0;
            run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          end
          p[PIN_NRE] = 1'b0;
          run[n] = mk_res(p, io, drv, 8'h00, 1'b0, ERR_OK); n = n + 1'b1;
          p[PIN_NRE] = 1'b1;
          run[n] = mk_res(p, io, drv, item.data.io_in, 1'b0, ERR_OK); n = n + 1'b1;
          if (item.last) begin
            drv = 1'b1;
            run[n] = mk_res(p, io, drv, item.data.io_in, 1'b0, ERR_OK);
            n = n + 1'b1;
          end
        end
      end
      ACT_POLL: begin
        run[n] = mk_res(p, io, drv, 8'h00, item.data.ready_in, ERR_OK); n = n + 1'b1;
      end
      default: begin
        // Unused action codes produce nothing and leave the pins alone.
        n = '0;
      end
    endcase
    cnt              = n;
    st_next.pins     = p;
    st_next.io_value = io;
    st_next.io_drive = drv;
  end

endmodule
